// ===== sv/ffpa_pkg.sv =====
package ffpa_pkg;

  localparam int SIZE_W = 24;
  localparam int AMT_W  = 20;
  localparam int NUM_W  = 5;

  typedef logic [SIZE_W-1:0] size_t;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_CLOSE = 2'd1,
    CMD_REQ   = 2'd2,
    CMD_BAD   = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_ORDER = 2'd2,
    ST_NOFIT = 2'd3
  } status_t;

  typedef struct packed {
    command_t         command;
    logic [AMT_W-1:0] amount;
  } cmd_t;

  typedef struct packed {
    status_t          status;
    logic             allocated;
    logic [NUM_W-1:0] partition_number;
    size_t            slack;
    size_t            free_total;
    size_t            internal_total;
  } res_t;

endpackage

// ===== sv/ffpa_alu.sv =====
module ffpa_alu (
  input  ffpa_pkg::size_t sum_a,
  input  ffpa_pkg::size_t sum_b,
  input  ffpa_pkg::size_t sub_c,
  input  ffpa_pkg::size_t sub_d,
  output ffpa_pkg::size_t sum,
  output ffpa_pkg::size_t diff,
  output logic            ge
);

  logic [ffpa_pkg::SIZE_W:0] sum_wide;

  // saturating add, plain subtract and compare
  assign sum_wide = {1'b0, sum_a} + {1'b0, sum_b};
  assign sum      = sum_wide[ffpa_pkg::SIZE_W] ? '1 : sum_wide[ffpa_pkg::SIZE_W-1:0];
  assign diff     = sub_c - sub_d;
  assign ge       = (sub_c >= sub_d);

endmodule

// ===== sv/ffpa_table.sv =====
module ffpa_table #(
  parameter  int DEPTH = 17,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  ffpa_pkg::size_t  wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output ffpa_pkg::size_t  rd_data
);

  ffpa_pkg::size_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/first_fit_partition_allocator.sv =====
// First-fit fixed-partition allocator.
// Command channel (cmd_valid, cmd_stall, cmd_word): load a partition size, close the list,
// or request memory. A word is taken when cmd_valid is high and cmd_stall is low.
// Result channel (res_valid, res_stall, res_word): exactly one result word per command,
// in command order, held steady while res_stall is high.
// cfg_we / cfg_data write total_memory; write it only while the block is idle.
// One command is worked on at a time; cmd_stall is high from acceptance until its result
// has been placed in the output register.
// Load, close and out-of-order commands pass through S_PREP and S_FINISH before the next
// acceptance. A request on a closed list goes to S_SCAN: the partition table is scanned one
// entry per cycle through the single read port of the size memory, with the shared
// adder and comparator testing the fit and summing the free sizes on each untaken entry.
// The result appears in the output register on the cycle after the last internal step.
// If the receiver stalls, the finished result waits in the output register and the
// block holds its final step until the register frees.
// Synchronous reset empties the list, clears taken flags, sums and the output valid flag;
// total_memory returns to zero. No clearing pass is needed.
module first_fit_partition_allocator #(
  parameter int MAX_PARTITIONS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_valid,
  output logic                     cmd_stall,
  input  ffpa_pkg::cmd_t           cmd_word,
  output logic                     res_valid,
  input  logic                     res_stall,
  output ffpa_pkg::res_t           res_word,
  input  logic                     cfg_we,
  input  logic [ffpa_pkg::SIZE_W-1:0] cfg_data
);

  localparam int DEPTH = MAX_PARTITIONS + 1;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_PREP   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;

  ffpa_pkg::size_t total_memory;
  logic [CNT_W-1:0] part_count;
  logic [DEPTH-1:0] part_taken;
  ffpa_pkg::size_t loaded_sum;
  ffpa_pkg::size_t free_sum;
  ffpa_pkg::size_t internal_sum;
  logic             list_closed;

  ffpa_pkg::cmd_t   cmd_q;
  ffpa_pkg::size_t  add_size;
  logic             add_ok;

  logic [CNT_W-1:0] rd_idx;
  logic             pend;
  logic [IDX_W-1:0] pend_idx;
  logic             found;
  logic [IDX_W-1:0] hit_idx;
  ffpa_pkg::size_t  frag_q;
  ffpa_pkg::size_t  acc;

  ffpa_pkg::size_t  sum_a, sum_b, sub_c, sub_d, alu_sum, alu_diff;
  logic             alu_ge;
  ffpa_pkg::size_t  amount_ext;
  ffpa_pkg::size_t  rd_data;
  logic             rd_en, wr_en;
  logic             slot_free, load_ok, accept, scan_done;
  logic [31:0]      new_num, hit_num;
  ffpa_pkg::res_t   res_next;

  assign amount_ext = {{(ffpa_pkg::SIZE_W-ffpa_pkg::AMT_W){1'b0}}, cmd_q.amount};
  assign slot_free  = !res_valid || !res_stall;
  assign cmd_stall  = (state != S_IDLE);
  assign accept     = cmd_valid && (state == S_IDLE);
  assign load_ok    = !list_closed && (part_count < CNT_W'(MAX_PARTITIONS));
  assign rd_en      = (state == S_SCAN) && (rd_idx < part_count);
  assign scan_done  = !pend && !rd_en;
  assign new_num    = 32'(part_count) + 32'd1;
  assign hit_num    = 32'(hit_idx) + 32'd1;

  assign wr_en = (state == S_FINISH) && slot_free &&
                 (((cmd_q.command == ffpa_pkg::CMD_LOAD) && load_ok) ||
                  ((cmd_q.command == ffpa_pkg::CMD_CLOSE) && !list_closed && add_ok));

  ffpa_table #(.DEPTH(DEPTH)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (part_count[IDX_W-1:0]),
    .wr_data (add_size),
    .rd_en   (rd_en),
    .rd_addr (rd_idx[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  ffpa_alu u_alu (
    .sum_a (sum_a),
    .sum_b (sum_b),
    .sub_c (sub_c),
    .sub_d (sub_d),
    .sum   (alu_sum),
    .diff  (alu_diff),
    .ge    (alu_ge)
  );

  // operand selection for the shared unit
  always_comb begin
    sum_a = '0;
    sum_b = '0;
    sub_c = '0;
    sub_d = '0;
    unique case (state)
      S_PREP: begin
        sum_a = loaded_sum;
        sum_b = amount_ext;
        sub_c = total_memory;
        sub_d = loaded_sum;
      end
      S_SCAN: begin
        sum_a = acc;
        sum_b = rd_data;
        sub_c = rd_data;
        sub_d = amount_ext;
      end
      S_FINISH: begin
        if (cmd_q.command == ffpa_pkg::CMD_REQ) begin
          sum_a = internal_sum;
          sum_b = frag_q;
        end else begin
          sum_a = free_sum;
          sum_b = add_size;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_next                   = '0;
    res_next.status            = ffpa_pkg::ST_ORDER;
    res_next.free_total        = free_sum;
    res_next.internal_total    = internal_sum;
    case (cmd_q.command)
      ffpa_pkg::CMD_LOAD: begin
        if (list_closed) begin
          res_next.status = ffpa_pkg::ST_ORDER;
        end else if (!load_ok) begin
          res_next.status = ffpa_pkg::ST_FULL;
        end else begin
          res_next.status           = ffpa_pkg::ST_OK;
          res_next.partition_number = new_num[ffpa_pkg::NUM_W-1:0];
          res_next.free_total       = alu_sum;
        end
      end
      ffpa_pkg::CMD_CLOSE: begin
        if (!list_closed) begin
          res_next.status = ffpa_pkg::ST_OK;
          if (add_ok) begin
            res_next.partition_number = new_num[ffpa_pkg::NUM_W-1:0];
            res_next.free_total       = alu_sum;
          end
        end
      end
      ffpa_pkg::CMD_REQ: begin
        if (list_closed) begin
          res_next.free_total = acc;
          if (found) begin
            res_next.status            = ffpa_pkg::ST_OK;
            res_next.allocated         = 1'b1;
            res_next.partition_number  = hit_num[ffpa_pkg::NUM_W-1:0];
            res_next.slack             = frag_q;
            res_next.internal_total    = alu_sum;
          end else begin
            res_next.status = ffpa_pkg::ST_NOFIT;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_memory <= '0;
    end else if (cfg_we) begin
      total_memory <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      part_count   <= '0;
      part_taken   <= '0;
      loaded_sum   <= '0;
      free_sum     <= '0;
      internal_sum <= '0;
      list_closed  <= 1'b0;
      res_valid    <= 1'b0;
      pend         <= 1'b0;
      found        <= 1'b0;
      rd_idx       <= '0;
    end else begin
      if ((state == S_FINISH) && slot_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_q  <= cmd_word;
            rd_idx <= '0;
            pend   <= 1'b0;
            found  <= 1'b0;
            acc    <= '0;
            if ((cmd_word.command == ffpa_pkg::CMD_REQ) && list_closed) begin
              state <= S_SCAN;
            end else begin
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          add_ok   <= 1'b0;
          add_size <= amount_ext;
          if ((cmd_q.command == ffpa_pkg::CMD_LOAD) && load_ok) begin
            loaded_sum <= alu_sum;
            add_ok     <= 1'b1;
          end else if (cmd_q.command == ffpa_pkg::CMD_CLOSE) begin
            add_size <= alu_diff;
            add_ok   <= alu_ge && (alu_diff != '0);
          end
          state <= S_FINISH;
        end
        S_SCAN: begin
          pend <= rd_en;
          if (rd_en) begin
            pend_idx <= rd_idx[IDX_W-1:0];
            rd_idx   <= rd_idx + 1'b1;
          end
          if (pend && !part_taken[pend_idx]) begin
            if (!found && alu_ge) begin
              found   <= 1'b1;
              hit_idx <= pend_idx;
              frag_q  <= alu_diff;
            end else begin
              acc <= alu_sum;
            end
          end
          if (scan_done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (slot_free) begin
            res_word  <= res_next;
            free_sum  <= res_next.free_total;
            if (wr_en) begin
              part_taken[part_count[IDX_W-1:0]] <= 1'b0;
              part_count <= part_count + 1'b1;
            end
            if ((cmd_q.command == ffpa_pkg::CMD_CLOSE) && !list_closed) begin
              list_closed <= 1'b1;
            end
            if ((cmd_q.command == ffpa_pkg::CMD_REQ) && list_closed && found) begin
              part_taken[hit_idx] <= 1'b1;
              internal_sum        <= alu_sum;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/ffpa_checker.sv =====
module ffpa_props (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_stall,
  input ffpa_pkg::cmd_t cmd_word,
  input logic           res_valid,
  input logic           res_stall,
  input ffpa_pkg::res_t res_word
);

  // result register empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_word))
    else $error("stalled result word changed");

  // one command at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("command taken while busy");

  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_word.status != ffpa_pkg::ST_OK) |->
      !res_word.allocated && (res_word.partition_number == '0) &&
      (res_word.slack == '0))
    else $error("rejected word carries placement");

  // cmd_word is part of the port set seen by the checker
  a_cmd_known: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd_word))
    else $error("stalled command word changed");

endmodule

bind first_fit_partition_allocator ffpa_props u_ffpa_props (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd_word  (cmd_word),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_word  (res_word)
);

// ===== sim/ffpa_checker.sv =====
`timescale 1ns / 1ps

module ffpa_checker #(
  parameter int MAX_PARTITIONS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  input  logic                        cmd_stall,
  input  ffpa_pkg::cmd_t              cmd_word,
  input  logic                        res_valid,
  input  logic                        res_stall,
  input  ffpa_pkg::res_t              res_word,
  input  logic                        cfg_we,
  input  logic [ffpa_pkg::SIZE_W-1:0] cfg_data,
  output int unsigned                 mismatches,
  output int unsigned                 waiting
);

  localparam int DEPTH  = MAX_PARTITIONS + 1;
  localparam int SIZE_W = ffpa_pkg::SIZE_W;
  localparam int NUM_W  = ffpa_pkg::NUM_W;

  ffpa_pkg::size_t part_sz   [DEPTH];
  logic            part_used [DEPTH];
  int unsigned     part_cnt;
  ffpa_pkg::size_t loaded_total;
  ffpa_pkg::size_t free_total;
  ffpa_pkg::size_t frag_total;
  ffpa_pkg::size_t mem_total;
  logic            closed;

  ffpa_pkg::res_t  due_results[$];

  function automatic ffpa_pkg::size_t sat_add(ffpa_pkg::size_t a, ffpa_pkg::size_t b);
    logic [SIZE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SIZE_W] ? '1 : s[SIZE_W-1:0];
  endfunction

  function automatic void recount_free();
    ffpa_pkg::size_t s;
    s = '0;
    for (int i = 0; i < part_cnt; i++) begin
      if (!part_used[i]) s = sat_add(s, part_sz[i]);
    end
    free_total = s;
  endfunction

  function automatic ffpa_pkg::res_t result_of(ffpa_pkg::cmd_t w);
    ffpa_pkg::res_t  r;
    ffpa_pkg::size_t amt;
    r = '0;
    r.status = ffpa_pkg::ST_OK;
    amt = SIZE_W'(w.amount);
    case (w.command)
      ffpa_pkg::CMD_LOAD: begin
        if (closed) begin
          r.status = ffpa_pkg::ST_ORDER;
        end else if (part_cnt >= MAX_PARTITIONS) begin
          r.status = ffpa_pkg::ST_FULL;
        end else begin
          part_sz[part_cnt] = amt;
          part_used[part_cnt] = 1'b0;
          part_cnt++;
          r.partition_number = NUM_W'(part_cnt);
          loaded_total = sat_add(loaded_total, amt);
          recount_free();
        end
      end
      ffpa_pkg::CMD_CLOSE: begin
        if (closed) begin
          r.status = ffpa_pkg::ST_ORDER;
        end else begin
          // remainder partition only when the loaded sizes fall short
          if (loaded_total < mem_total && part_cnt < DEPTH) begin
            part_sz[part_cnt] = mem_total - loaded_total;
            part_used[part_cnt] = 1'b0;
            part_cnt++;
            r.partition_number = NUM_W'(part_cnt);
            recount_free();
          end
          closed = 1'b1;
        end
      end
      ffpa_pkg::CMD_REQ: begin
        if (!closed) begin
          r.status = ffpa_pkg::ST_ORDER;
        end else begin
          r.status = ffpa_pkg::ST_NOFIT;
          for (int i = 0; i < part_cnt; i++) begin
            if (!part_used[i] && amt <= part_sz[i]) begin
              part_used[i] = 1'b1;
              r.slack = part_sz[i] - amt;
              frag_total = sat_add(frag_total, r.slack);
              r.status = ffpa_pkg::ST_OK;
              r.allocated = 1'b1;
              r.partition_number = NUM_W'(i + 1);
              break;
            end
          end
          recount_free();
        end
      end
      default: begin
        r.status = ffpa_pkg::ST_ORDER;
      end
    endcase
    r.free_total = free_total;
    r.internal_total = frag_total;
    return r;
  endfunction

  task automatic check_field(string name, logic [SIZE_W-1:0] want,
                             logic [SIZE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  initial mismatches = 0;

  always @(posedge clk) begin : watch
    ffpa_pkg::res_t want;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        part_sz[i] = '0;
        part_used[i] = 1'b0;
      end
      part_cnt = 0;
      loaded_total = '0;
      free_total = '0;
      frag_total = '0;
      mem_total = '0;
      closed = 1'b0;
      due_results.delete();
    end else begin
      if (res_valid && !res_stall) begin
        if (due_results.size() == 0) begin
          $error("result word with nothing expected: %h", res_word);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("status", SIZE_W'(want.status), SIZE_W'(res_word.status));
          check_field("allocated", SIZE_W'(want.allocated), SIZE_W'(res_word.allocated));
          check_field("partition_number", SIZE_W'(want.partition_number),
                      SIZE_W'(res_word.partition_number));
          check_field("slack", want.slack, res_word.slack);
          check_field("free_total", want.free_total, res_word.free_total);
          check_field("internal_total", want.internal_total, res_word.internal_total);
        end
      end
      if (cmd_valid && !cmd_stall) due_results.push_back(result_of(cmd_word));
      if (cfg_we) mem_total = cfg_data;
    end
    waiting <= due_results.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int SIZE_W = ffpa_pkg::SIZE_W;
  localparam int AMT_W  = ffpa_pkg::AMT_W;

  logic              clk = 1'b0;
  logic              rst;
  logic              cmd_valid;
  logic              cmd_stall;
  ffpa_pkg::cmd_t    cmd_word;
  logic              res_valid;
  logic              res_stall;
  ffpa_pkg::res_t    res_word;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_data;

  int unsigned       mismatches;
  int unsigned       waiting;
  bit                calm = 1'b0;

  first_fit_partition_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_word  (cmd_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  ffpa_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd_word   (cmd_word),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_word   (res_word),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .waiting    (waiting)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver: short random holds, two long ones to back the block up
  initial begin : rx_side
    int unsigned left;
    int unsigned cyc;
    left = 0;
    cyc = 0;
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (!calm) begin
        if (cyc == 1500 || cyc == 4000) begin
          left = 300;
        end else if (left == 0 && $urandom_range(0, 7) == 0) begin
          left = $urandom_range(1, 14);
        end
      end
      if (left != 0) begin
        res_stall <= 1'b1;
        left--;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  task automatic offer_cmd(ffpa_pkg::command_t c, logic [AMT_W-1:0] a);
    int unsigned n;
    ffpa_pkg::cmd_t w;
    w.command = c;
    w.amount = a;
    if (!calm && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      n = $urandom_range(1, 14);
      repeat (n) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_word <= w;
    do @(posedge clk); while (cmd_stall);
  endtask

  task automatic drain_results();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  task automatic set_total_memory(logic [SIZE_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [AMT_W-1:0] request_amount();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return AMT_W'($urandom_range(0, 255));
    if (pick < 60) return AMT_W'($urandom_range(0, 65535));
    if (pick < 85) return AMT_W'($urandom());
    if (pick < 95) return '0;
    return '1;
  endfunction

  initial begin : stimulus
    int unsigned load_sum;
    int unsigned mode;
    logic [AMT_W-1:0] a;
    logic [SIZE_W-1:0] mem;
    rst <= 1'b1;
    cmd_valid <= 1'b0;
    cmd_word <= '0;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_total_memory('0);
    set_total_memory('1);

    // requests and bad commands before the list is closed
    offer_cmd(ffpa_pkg::CMD_REQ, AMT_W'(5));
    offer_cmd(ffpa_pkg::CMD_BAD, '1);

    // fill the table, then one load too many
    load_sum = 0;
    offer_cmd(ffpa_pkg::CMD_LOAD, '0);
    offer_cmd(ffpa_pkg::CMD_LOAD, '1);
    load_sum = (1 << AMT_W) - 1;
    for (int i = 0; i < 14; i++) begin
      a = $urandom_range(0, 1) ? AMT_W'($urandom_range(1, 4096)) : AMT_W'($urandom());
      load_sum += a;
      offer_cmd(ffpa_pkg::CMD_LOAD, a);
    end
    offer_cmd(ffpa_pkg::CMD_LOAD, AMT_W'($urandom()));

    drain_results();
    mode = $urandom_range(0, 9);
    if (mode < 6) mem = '1;
    else if (mode == 6) mem = SIZE_W'(load_sum);
    else if (mode == 7) mem = SIZE_W'(load_sum + 1);
    else if (mode == 8) mem = '0;
    else mem = SIZE_W'($urandom());
    set_total_memory(mem);

    offer_cmd(ffpa_pkg::CMD_CLOSE, AMT_W'($urandom()));
    offer_cmd(ffpa_pkg::CMD_CLOSE, '0);
    offer_cmd(ffpa_pkg::CMD_LOAD, AMT_W'(7));
    offer_cmd(ffpa_pkg::CMD_REQ, '0);
    offer_cmd(ffpa_pkg::CMD_REQ, '1);
    offer_cmd(ffpa_pkg::CMD_BAD, '0);

    for (int i = 0; i < 930; i++) begin
      if (i == 450) begin
        drain_results();
        set_total_memory('0);
      end
      if (i == 830) calm = 1'b1;
      if ($urandom_range(0, 99) < 75) begin
        offer_cmd(ffpa_pkg::CMD_REQ, request_amount());
      end else begin
        offer_cmd(ffpa_pkg::command_t'($urandom_range(0, 3)), AMT_W'($urandom()));
      end
    end

    drain_results();
    repeat (30) @(posedge clk);
    if (mismatches == 0 && waiting == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ffpa_pkg.sv
sv/ffpa_alu.sv
sv/ffpa_table.sv
sv/first_fit_partition_allocator.sv
sv/ffpa_checker.sv
sim/ffpa_checker.sv
sim/tb_top.sv
